// File: src/twcd_pkg.sv
package twcd_pkg;

  localparam int MAX_SETS = 256;
  localparam int WAYS     = 2;

  localparam int ADDR_W   = 32;
  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int OFF_W    = 12;
  localparam int TAG_W    = 26;
  localparam int ENTRY_W  = TAG_W + 1;
  localparam int CFG_W    = 4;
  localparam int WAY_W    = 1;

  // Register indexes of the configuration port.
  localparam logic [0:0] CFG_SET_INDEX_BITS   = 1'b0;
  localparam logic [0:0] CFG_LINE_OFFSET_BITS = 1'b1;

  localparam logic [CFG_W-1:0] IDX_BITS_RST = 4'd6;
  localparam logic [CFG_W-1:0] OFF_BITS_RST = 4'd8;
  localparam logic [CFG_W-1:0] IDX_BITS_MIN = 4'd1;
  localparam logic [CFG_W-1:0] IDX_BITS_MAX = CFG_W'(SET_W);
  localparam logic [CFG_W-1:0] OFF_BITS_MIN = 4'd5;
  localparam logic [CFG_W-1:0] OFF_BITS_MAX = 4'd12;

  localparam logic [ADDR_W-1:0]  FILL_MASK   = 32'hFFFF_FFE0;
  localparam logic [ENTRY_W-1:0] TAG_INVALID = {ENTRY_W{1'b1}};

  // One set of the directory: the most recent way and both stored tags.
  typedef struct packed {
    logic                           recent;
    logic [WAYS-1:0][ENTRY_W-1:0]   tags;
  } row_t;

  localparam row_t ROW_RESET = '{recent: 1'b0, tags: {WAYS{TAG_INVALID}}};

  // Address fields of one request.
  typedef struct packed {
    logic [SET_W-1:0]  set_index;
    logic [OFF_W-1:0]  line_offset;
    logic [TAG_W-1:0]  address_tag;
    logic [ADDR_W-1:0] fill_address;
    logic [ADDR_W-1:0] line_base;
  } fields_t;

  // Outcome of the tag compare and the updated set contents.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             recent_way;
    row_t             new_row;
  } lookup_t;

endpackage

// File: src/two_way_cache_tag_directory.sv
// Tag directory of a read-only two-way set-associative cache.
// Issue a lookup by raising start with in_address and in_action for one
// cycle; the request transfers at any rising edge where start is high and
// busy is low. busy stays low, so a new request can transfer every cycle.
// Each request yields exactly one result, shown for a single cycle while
// out_strobe is high: the set is read from the tag memory into a register
// as the request transfers, then compared and captured in the result
// register. The receiver cannot stall the block and must take
// every result in the cycle it is shown.
// An access (in_action high) writes the updated set back in the compare
// cycle; a request to the same set in the very next cycle picks up that
// write through a forwarding register, so back-to-back accesses are exact.
// cfg_we writes set_index_bits (index 0) or line_offset_bits (index 1);
// change them only while no request is in flight.
// Reset restores widths 6 and 8 and marks every set as never written, so all
// tags read as invalid and every most-recent mark as way 0 at once; no
// clearing pass is needed.
module two_way_cache_tag_directory (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [twcd_pkg::ADDR_W-1:0]   in_address,
  input  logic                          in_action,
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic                          out_way,
  output logic [twcd_pkg::SET_W-1:0]    out_set_index,
  output logic [twcd_pkg::OFF_W-1:0]    out_line_offset,
  output logic [twcd_pkg::TAG_W-1:0]    out_address_tag,
  output logic [twcd_pkg::ADDR_W-1:0]   out_fill_address,
  output logic [twcd_pkg::ADDR_W-1:0]   out_line_base,
  output logic                          out_recent_way,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [twcd_pkg::CFG_W-1:0]    cfg_data
);

  logic [twcd_pkg::CFG_W-1:0] idx_bits_r;
  logic [twcd_pkg::CFG_W-1:0] off_bits_r;

  logic                accept;
  twcd_pkg::fields_t   split;

  // Stage 1: request waiting for the set read.
  logic                s1_vld_r;
  logic                s1_action_r;
  twcd_pkg::fields_t   s1_fields_r;
  logic                fwd_r;
  logic                fwd_nxt;
  twcd_pkg::row_t      fwd_row_r;

  twcd_pkg::row_t      ram_row;
  twcd_pkg::row_t      cur_row;
  twcd_pkg::lookup_t   lk;
  logic                wr_en;

  // Result register.
  logic                out_strobe_r;
  logic                out_hit_r;
  logic                out_way_r;
  logic                out_recent_r;
  twcd_pkg::fields_t   out_fields_r;

  // The directory never holds a request off.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_bits_r <= twcd_pkg::IDX_BITS_RST;
      off_bits_r <= twcd_pkg::OFF_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        twcd_pkg::CFG_SET_INDEX_BITS:   idx_bits_r <= cfg_data;
        twcd_pkg::CFG_LINE_OFFSET_BITS: off_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  twcd_addr_split u_split (
    .address  (in_address),
    .idx_bits (idx_bits_r),
    .off_bits (off_bits_r),
    .fields   (split)
  );

  twcd_tag_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (wr_en),
    .waddr (s1_fields_r.set_index),
    .wdata (lk.new_row),
    .raddr (split.set_index),
    .rdata (ram_row)
  );

  // A write to the set being read in the same cycle is not seen by the
  // memory read, so the written row is carried alongside instead.
  assign wr_en   = s1_vld_r & s1_action_r;
  assign fwd_nxt = accept & wr_en & (s1_fields_r.set_index == split.set_index);
  assign cur_row = fwd_r ? fwd_row_r : ram_row;

  twcd_lookup u_lookup (
    .row         (cur_row),
    .address_tag (s1_fields_r.address_tag),
    .result      (lk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      fwd_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= accept;
      fwd_r        <= fwd_nxt;
      out_strobe_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_action_r  <= in_action;
    s1_fields_r  <= split;
    fwd_row_r    <= lk.new_row;
    out_hit_r    <= lk.hit;
    out_way_r    <= lk.way;
    out_recent_r <= lk.recent_way;
    out_fields_r <= s1_fields_r;
  end

  assign out_strobe       = out_strobe_r;
  assign out_hit          = out_hit_r;
  assign out_way          = out_way_r;
  assign out_recent_way   = out_recent_r;
  assign out_set_index    = out_fields_r.set_index;
  assign out_line_offset  = out_fields_r.line_offset;
  assign out_address_tag  = out_fields_r.address_tag;
  assign out_fill_address = out_fields_r.fill_address;
  assign out_line_base    = out_fields_r.line_base;

  // Forwarding is only ever armed by an access write in the cycle before.
  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(wr_en))
    else $error("forwarded row without a preceding write");

  // Every transferred request produces a result, after the stage 1 and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("result missing for a transferred request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |=> !out_strobe)
    else $error("result shown without a request");

  // On a miss the victim is the way that was not most recent.
  a_victim_lru: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_way != out_recent_way))
    else $error("victim way equals the most recent way");

endmodule

// File: src/twcd_addr_split.sv
module twcd_addr_split (
  input  logic [twcd_pkg::ADDR_W-1:0] address,
  input  logic [twcd_pkg::CFG_W-1:0]  idx_bits,
  input  logic [twcd_pkg::CFG_W-1:0]  off_bits,
  output twcd_pkg::fields_t           fields
);

  logic [twcd_pkg::CFG_W-1:0]  ib;
  logic [twcd_pkg::CFG_W-1:0]  ob;
  logic [twcd_pkg::ADDR_W-1:0] off_mask;
  logic [twcd_pkg::ADDR_W-1:0] above_off;
  logic [twcd_pkg::ADDR_W-1:0] above_idx;
  logic [twcd_pkg::SET_W-1:0]  idx_mask;

  // Out-of-range widths saturate to the nearest legal width.
  always_comb begin
    if (idx_bits < twcd_pkg::IDX_BITS_MIN) begin
      ib = twcd_pkg::IDX_BITS_MIN;
    end else if (idx_bits > twcd_pkg::IDX_BITS_MAX) begin
      ib = twcd_pkg::IDX_BITS_MAX;
    end else begin
      ib = idx_bits;
    end
    if (off_bits < twcd_pkg::OFF_BITS_MIN) begin
      ob = twcd_pkg::OFF_BITS_MIN;
    end else if (off_bits > twcd_pkg::OFF_BITS_MAX) begin
      ob = twcd_pkg::OFF_BITS_MAX;
    end else begin
      ob = off_bits;
    end
  end

  assign off_mask  = ~({twcd_pkg::ADDR_W{1'b1}} << ob);
  assign above_off = address >> ob;
  assign above_idx = above_off >> ib;
  assign idx_mask  = ~({twcd_pkg::SET_W{1'b1}} << ib);

  always_comb begin
    fields.set_index    = above_off[twcd_pkg::SET_W-1:0] & idx_mask;
    fields.line_offset  = address[twcd_pkg::OFF_W-1:0] & off_mask[twcd_pkg::OFF_W-1:0];
    fields.address_tag  = above_idx[twcd_pkg::TAG_W-1:0];
    fields.fill_address = address & twcd_pkg::FILL_MASK;
    fields.line_base    = address & ~off_mask;
  end

endmodule

// File: src/twcd_tag_store.sv
module twcd_tag_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [twcd_pkg::SET_W-1:0] waddr,
  input  twcd_pkg::row_t             wdata,
  input  logic [twcd_pkg::SET_W-1:0] raddr,
  output twcd_pkg::row_t             rdata
);

  twcd_pkg::row_t                  mem [twcd_pkg::MAX_SETS];
  logic [twcd_pkg::MAX_SETS-1:0]   row_vld_r;
  twcd_pkg::row_t                  rd_q_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[raddr];
  end

  // A set that was never written reads as its reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (we) begin
        row_vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= row_vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : twcd_pkg::ROW_RESET;

endmodule

// File: src/twcd_lookup.sv
module twcd_lookup (
  input  twcd_pkg::row_t             row,
  input  logic [twcd_pkg::TAG_W-1:0] address_tag,
  output twcd_pkg::lookup_t          result
);

  logic [twcd_pkg::ENTRY_W-1:0] tag_ext;
  logic                         match0;
  logic                         match1;

  assign tag_ext = {1'b0, address_tag};
  assign match0  = (row.tags[0] == tag_ext);
  assign match1  = (row.tags[1] == tag_ext);

  always_comb begin
    result.hit        = match0 | match1;
    result.recent_way = row.recent;
    // Way 1 wins when both match; on a miss the victim is the older way.
    if (match1) begin
      result.way = 1'b1;
    end else if (match0) begin
      result.way = 1'b0;
    end else begin
      result.way = ~row.recent;
    end
    result.new_row        = row;
    result.new_row.recent = result.way;
    if (!result.hit) begin
      result.new_row.tags[result.way] = tag_ext;
    end
  end

endmodule

// File: tb/twcd_lookup_checker.sv
`timescale 1ns / 1ps

module twcd_lookup_checker
  import twcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_action,
  input  logic              out_strobe,
  input  logic              out_hit,
  input  logic              out_way,
  input  logic [SET_W-1:0]  out_set_index,
  input  logic [OFF_W-1:0]  out_line_offset,
  input  logic [TAG_W-1:0]  out_address_tag,
  input  logic [ADDR_W-1:0] out_fill_address,
  input  logic [ADDR_W-1:0] out_line_base,
  input  logic              out_recent_way,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                mismatch_count,
  output int                outstanding,
  output int                lookups_checked,
  output int                hits_checked
);

  typedef struct packed {
    logic              hit;
    logic              way;
    logic [SET_W-1:0]  set_index;
    logic [OFF_W-1:0]  line_offset;
    logic [TAG_W-1:0]  address_tag;
    logic [ADDR_W-1:0] fill_address;
    logic [ADDR_W-1:0] line_base;
    logic              recent_way;
  } lookup_result_t;

  // Shadow copy of the directory and of the two width registers.
  logic [ENTRY_W-1:0] tag_mem [MAX_SETS][WAYS];
  logic               recent_mem [MAX_SETS];
  logic [CFG_W-1:0]   idx_setting;
  logic [CFG_W-1:0]   offset_bits;

  lookup_result_t expected_lookups [$];
  int             error_total;
  int             checked_total;
  int             hit_total;

  // Works out the result of one request and applies an access to the shadow
  // directory, in request order.
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr,
                                                    input logic act);
    lookup_result_t   r;
    logic [CFG_W-1:0] ib;
    logic [CFG_W-1:0] ob;
    logic [31:0]      off_mask;
    logic [31:0]      set_no;
    logic [31:0]      tag_val;
    logic             recent_mark;
    logic             hit_any;
    logic             way_sel;
    ib = idx_setting;
    if (ib < IDX_BITS_MIN) ib = IDX_BITS_MIN;
    if (ib > IDX_BITS_MAX) ib = IDX_BITS_MAX;
    ob = offset_bits;
    if (ob < OFF_BITS_MIN) ob = OFF_BITS_MIN;
    if (ob > OFF_BITS_MAX) ob = OFF_BITS_MAX;
    off_mask = (32'd1 << ob) - 32'd1;
    set_no   = (addr >> ob) & ((32'd1 << ib) - 32'd1);
    tag_val  = (addr >> ob) >> ib;
    recent_mark = recent_mem[set_no];
    hit_any = 1'b0;
    way_sel = 1'b0;
    // A later way wins if both match.
    for (int w = 0; w < WAYS; w++) begin
      if (tag_mem[set_no][w] == {1'b0, tag_val[TAG_W-1:0]}) begin
        hit_any = 1'b1;
        way_sel = w[0];
      end
    end
    if (!hit_any) way_sel = ~recent_mark;
    if (act) begin
      if (!hit_any) tag_mem[set_no][way_sel] = {1'b0, tag_val[TAG_W-1:0]};
      recent_mem[set_no] = way_sel;
    end
    r.hit          = hit_any;
    r.way          = way_sel;
    r.set_index    = set_no[SET_W-1:0];
    r.line_offset  = addr[OFF_W-1:0] & off_mask[OFF_W-1:0];
    r.address_tag  = tag_val[TAG_W-1:0];
    r.fill_address = addr & FILL_MASK;
    r.line_base    = addr & ~off_mask;
    r.recent_way   = recent_mark;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: lookup %0d, %s: got %h, expected %h", $realtime, checked_total,
             what, got, want);
    error_total++;
  endtask

  always @(posedge clk) begin
    lookup_result_t exp_res;
    if (!rst_n) begin
      for (int s = 0; s < MAX_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) tag_mem[s][w] = TAG_INVALID;
        recent_mem[s] = 1'b0;
      end
      idx_setting   = IDX_BITS_RST;
      offset_bits   = OFF_BITS_RST;
      error_total   = 0;
      checked_total = 0;
      hit_total     = 0;
      expected_lookups.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_INDEX_BITS:   idx_setting = cfg_data;
          CFG_LINE_OFFSET_BITS: offset_bits = cfg_data;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_address_tag), '0);
        end else begin
          exp_res = expected_lookups.pop_front();
          if (out_hit !== exp_res.hit)
            report_mismatch("hit", 32'(out_hit), 32'(exp_res.hit));
          if (out_way !== exp_res.way)
            report_mismatch("way", 32'(out_way), 32'(exp_res.way));
          if (out_set_index !== exp_res.set_index)
            report_mismatch("set_index", 32'(out_set_index), 32'(exp_res.set_index));
          if (out_line_offset !== exp_res.line_offset)
            report_mismatch("line_offset", 32'(out_line_offset),
                            32'(exp_res.line_offset));
          if (out_address_tag !== exp_res.address_tag)
            report_mismatch("address_tag", 32'(out_address_tag),
                            32'(exp_res.address_tag));
          if (out_fill_address !== exp_res.fill_address)
            report_mismatch("fill_address", out_fill_address, exp_res.fill_address);
          if (out_line_base !== exp_res.line_base)
            report_mismatch("line_base", out_line_base, exp_res.line_base);
          if (out_recent_way !== exp_res.recent_way)
            report_mismatch("recent_way", 32'(out_recent_way), 32'(exp_res.recent_way));
          if (exp_res.hit) hit_total++;
          checked_total++;
        end
      end
      if (start && !busy) expected_lookups.push_back(predict_lookup(in_address, in_action));
    end
    mismatch_count  <= error_total;
    outstanding     <= expected_lookups.size();
    lookups_checked <= checked_total;
    hits_checked    <= hit_total;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Top of the tag directory testbench. It makes the clock and the reset, drives
// lookups and width settings, and gives the verdict. All prediction and
// comparison lives in the lookup checker that sits beside the block.
module tb_top;
  import twcd_pkg::*;

  // A run stalls if this many cycles pass with no transfer of any kind.
  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ADDR_W-1:0] in_address = '0;
  logic              in_action = 1'b0;
  logic              out_strobe;
  logic              out_hit;
  logic              out_way;
  logic [SET_W-1:0]  out_set_index;
  logic [OFF_W-1:0]  out_line_offset;
  logic [TAG_W-1:0]  out_address_tag;
  logic [ADDR_W-1:0] out_fill_address;
  logic [ADDR_W-1:0] out_line_base;
  logic              out_recent_way;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_SET_INDEX_BITS;
  logic [CFG_W-1:0]  cfg_data = '0;

  int mismatch_count;
  int outstanding;
  int lookups_checked;
  int hits_checked;
  int stall_cycles = 0;

  // Widths in effect, after the block's clamping. The random address maker
  // uses them to place tags and set numbers where the block will look.
  int cur_ib = int'(IDX_BITS_RST);
  int cur_ob = int'(OFF_BITS_RST);

  // Recently sent addresses, reused so that a good share of lookups hit.
  logic [ADDR_W-1:0] recent_addrs [$];

  always #6 clk = ~clk;

  two_way_cache_tag_directory uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_address       (in_address),
    .in_action        (in_action),
    .out_strobe       (out_strobe),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_set_index    (out_set_index),
    .out_line_offset  (out_line_offset),
    .out_address_tag  (out_address_tag),
    .out_fill_address (out_fill_address),
    .out_line_base    (out_line_base),
    .out_recent_way   (out_recent_way),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  twcd_lookup_checker u_lookup_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_address       (in_address),
    .in_action        (in_action),
    .out_strobe       (out_strobe),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_set_index    (out_set_index),
    .out_line_offset  (out_line_offset),
    .out_address_tag  (out_address_tag),
    .out_fill_address (out_fill_address),
    .out_line_base    (out_line_base),
    .out_recent_way   (out_recent_way),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding),
    .lookups_checked  (lookups_checked),
    .hits_checked     (hits_checked)
  );

  // Watchdog: every request transfer, result or register write restarts the
  // count. A block that hangs, or never raises its strobe, ends the run here.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[two_way_cache_tag_directory] ERROR");
      $finish;
    end
  end

  // Presents one request after an optional idle gap and returns at the edge
  // where it transfers. The gap is drawn cycle by cycle: each cycle idles
  // with the given chance in a hundred. start is only lowered when there is
  // a gap, so back-to-back requests keep it high without a glitch.
  task automatic send_request(input logic [ADDR_W-1:0] addr, input logic act,
                              input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_address <= addr;
    in_action  <= act;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every result is back, then writes both width registers.
  // The first edge makes sure the count of pending lookups already includes
  // a request that transferred at the edge we were called on.
  task automatic program_widths(input logic [CFG_W-1:0] ib_raw,
                                input logic [CFG_W-1:0] ob_raw);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_INDEX_BITS;
    cfg_data  <= ib_raw;
    @(posedge clk);
    cfg_index <= CFG_LINE_OFFSET_BITS;
    cfg_data  <= ob_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    // Out-of-range settings clamp inside the block; track what it will use.
    cur_ib = int'((ib_raw < IDX_BITS_MIN) ? IDX_BITS_MIN :
                  (ib_raw > IDX_BITS_MAX) ? IDX_BITS_MAX : ib_raw);
    cur_ob = int'((ob_raw < OFF_BITS_MIN) ? OFF_BITS_MIN :
                  (ob_raw > OFF_BITS_MAX) ? OFF_BITS_MAX : ob_raw);
  endtask

  // Random lookups. Most addresses carry one of a handful of small tags and
  // land in a few sets, so that sets fill, evict and hit again and the most
  // recent mark keeps flipping. Some reuse a recent line with a new offset,
  // and some are fully random so that every address bit toggles.
  task automatic send_random(input int count, input int idle_pct);
    logic [ADDR_W-1:0] addr;
    logic [31:0]       off_mask;
    logic [31:0]       set_mask;
    logic [31:0]       tag_val;
    int                pick;
    for (int i = 0; i < count; i++) begin
      off_mask = (32'd1 << cur_ob) - 32'd1;
      set_mask = (32'd1 << cur_ib) - 32'd1;
      pick = $urandom_range(99);
      if (pick < 15) begin
        addr = $urandom();
      end else if (pick < 45 && recent_addrs.size() > 0) begin
        addr = (recent_addrs[$urandom_range(recent_addrs.size() - 1)] & ~off_mask) |
               ($urandom() & off_mask);
      end else begin
        tag_val = $urandom_range(3);
        addr = (tag_val << (cur_ob + cur_ib)) |
               ((($urandom() & set_mask) & ((pick < 80) ? 32'h3 : 32'hFF)) << cur_ob) |
               ($urandom() & off_mask);
      end
      recent_addrs.push_back(addr);
      if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
      send_request(addr, ($urandom_range(99) < 70), idle_pct);
    end
  endtask

  initial begin
    // Apply reset once, at the start.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset widths (index 6, offset 8), all in set 0
    // unless noted. A query on an empty set misses and leaves it empty, an
    // access fills the victim way, a third tag evicts the older line, and a
    // hit moves the most recent mark.
    send_request(32'h0000_0000, 1'b0, 0);
    send_request(32'h0000_0000, 1'b1, 0);
    send_request(32'h0000_00FF, 1'b0, 0);
    send_request(32'h0000_4000, 1'b1, 0);
    send_request(32'h0000_8000, 1'b1, 0);
    send_request(32'h0000_0000, 1'b0, 0);
    send_request(32'h0000_4000, 1'b1, 0);
    send_request(32'h0000_8010, 1'b0, 0);
    // Address extremes and alternating bit patterns, including the top set.
    send_request(32'hFFFF_FFFF, 1'b0, 0);
    send_request(32'hFFFF_FFFF, 1'b1, 0);
    send_request(32'hFFFF_FFFF, 1'b1, 0);
    send_request(32'h0000_3F00, 1'b1, 0);
    send_request(32'h8000_0000, 1'b1, 0);
    send_request(32'hAAAA_AAAA, 1'b1, 0);
    send_request(32'h5555_5555, 1'b1, 0);
    send_request(32'hAAAA_AAAA, 1'b0, 0);
    send_request($urandom(), 1'b1, 7);
    send_random(150, 7);

    // Register values of zero clamp to the narrowest split (index 1, offset 5),
    // which gives the widest tag; the stored tags from the previous split stay
    // in place and are compared as they are.
    program_widths(4'd0, 4'd0);
    send_request(32'hFFFF_FFFF, 1'b1, 0);
    send_request(32'hFFFF_FFFF, 1'b0, 0);
    send_request(32'h0000_0000, 1'b0, 0);
    send_random(150, 7);

    // All-ones register values clamp to the widest split (index 8, offset 12).
    program_widths(4'd15, 4'd15);
    send_request(32'hFFFF_FFFF, 1'b1, 0);
    send_request(32'h000F_F000, 1'b1, 0);
    send_request(32'h0000_0FFF, 1'b0, 0);
    send_random(150, 7);

    // Sender now idles often.
    program_widths(IDX_BITS_MIN, OFF_BITS_MIN);
    send_random(200, 58);
    program_widths(IDX_BITS_MAX, OFF_BITS_MAX);
    send_random(200, 58);

    // Back-to-back requests with no idling at all.
    program_widths(4'd3, 4'd9);
    send_random(150, 0);
    program_widths(IDX_BITS_RST, OFF_BITS_RST);
    send_random(200, 0);

    // Drain, then allow a few more cycles in case a stray result shows up.
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d lookups (%0d hits) over seven width settings,", lookups_checked,
             hits_checked);
    $display("including both clamped extremes and three idle profiles.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[two_way_cache_tag_directory] OK");
    end else begin
      $display("%0d mismatches, %0d lookups still expected", mismatch_count, outstanding);
      $display("[two_way_cache_tag_directory] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/twcd_pkg.sv
src/twcd_addr_split.sv
src/twcd_tag_store.sv
src/twcd_lookup.sv
src/two_way_cache_tag_directory.sv
tb/twcd_lookup_checker.sv
tb/tb_top.sv
